[rtl/sac_pkg.sv]
package sac_pkg;

    localparam int MAX_WAYS   = 8;
    localparam int MAX_SETS   = 256;
    localparam int ADDR_WIDTH = 32;
    localparam int AGE_WIDTH  = 16;

    localparam int WAY_W  = $clog2(MAX_WAYS);
    localparam int SET_W  = $clog2(MAX_SETS);
    localparam int SLOT_W = SET_W + WAY_W;

    localparam int IDX_W      = 4;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 6;
    localparam int OUT_DATA_W = 48;

    localparam logic [AGE_WIDTH-1:0] AGE_MAX = '1;

    // Register indexes of the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_ADDRESS_BITS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_OFFSET_BITS  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_INDEX_BITS   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_WAYS_IN_USE  = 2'd3;

    localparam logic [5:0] RST_ADDRESS_BITS = 6'd20;
    localparam logic [4:0] RST_OFFSET_BITS  = 5'd4;
    localparam logic [3:0] RST_INDEX_BITS   = 4'd6;
    localparam logic [3:0] RST_WAYS_IN_USE  = 4'd4;

    typedef logic [MAX_WAYS-1:0][AGE_WIDTH-1:0] age_row_t;

    // One set's replacement state: valid marks and ages of all ways
    typedef struct packed {
        age_row_t            age;
        logic [MAX_WAYS-1:0] valid;
    } row_t;

endpackage

[rtl/set_assoc_cache_lru_tags_core.sv]
// One address is accepted at a time: s_tready is high only in IDLE, and a lookup passes
// through PREP, READ, LOAD, SCAN and WB before the next is taken. A single compare/age unit
// visits the ways of the set one per cycle, reading one tag per cycle from the tag RAM.
// The result register frees the input side while a result waits to be taken.
// Reset (rst_n, async, active low) loads the register defaults and clears the
// per-set valid flags, so every set starts empty; no clearing pass is needed.
module set_assoc_cache_lru_tags_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [sac_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [sac_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sac_pkg::ADDR_WIDTH-1:0]      s_tdata,   // [31:0] address
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sac_pkg::OUT_DATA_W-1:0]      m_tdata    // [0] hit, [8:1] set_number,
                                                           // [11:9] way_number, [43:12] tag_value
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_READ = 3'd2;
    localparam logic [2:0] ST_LOAD = 3'd3;
    localparam logic [2:0] ST_SCAN = 3'd4;
    localparam logic [2:0] ST_WB   = 3'd5;

    logic [2:0] state_reg, state_next;

    logic [5:0] address_bits_reg;
    logic [4:0] offset_bits_reg;
    logic [3:0] index_bits_reg;
    logic [3:0] ways_in_use_reg;

    logic [sac_pkg::ADDR_WIDTH-1:0] addr_reg;
    logic [sac_pkg::SET_W-1:0]      set_reg;
    logic [sac_pkg::ADDR_WIDTH-1:0] tag_reg;
    logic [sac_pkg::WAY_W-1:0]      w_reg;
    logic [sac_pkg::MAX_WAYS-1:0]   valid_reg;
    sac_pkg::age_row_t              ages_reg;
    logic                           hit_reg;
    logic [sac_pkg::WAY_W-1:0]      way_reg;
    logic                           free_reg;
    logic [sac_pkg::WAY_W-1:0]      victim_reg;
    logic [sac_pkg::AGE_WIDTH-1:0]  best_reg;

    logic [sac_pkg::MAX_SETS-1:0]   row_valid_reg;

    logic                           out_valid_reg;
    logic                           out_hit_reg;
    logic [sac_pkg::SET_W-1:0]      out_set_reg;
    logic [sac_pkg::WAY_W-1:0]      out_way_reg;
    logic [sac_pkg::ADDR_WIDTH-1:0] out_tag_reg;

    // Memories
    sac_pkg::row_t                  row_mem [sac_pkg::MAX_SETS];
    logic [sac_pkg::ADDR_WIDTH-1:0] tag_mem [sac_pkg::MAX_SETS * sac_pkg::MAX_WAYS];
    sac_pkg::row_t                  row_q;
    logic [sac_pkg::ADDR_WIDTH-1:0] tag_q;

    logic                           row_re, row_we, tag_re, tag_we;
    sac_pkg::row_t                  row_wdata;
    logic [sac_pkg::SLOT_W-1:0]     tag_raddr, tag_waddr;

    logic                           accept;
    logic                           out_free;
    logic [5:0]                     ab;
    logic [32:0]                    addr_mask;
    logic [3:0]                     ib;
    logic [8:0]                     set_mask;
    logic [5:0]                     tag_shift;
    logic [sac_pkg::WAY_W-1:0]      last_w;
    logic [sac_pkg::AGE_WIDTH-1:0]  age_cur, age_new;
    logic                           match;
    logic                           miss_wb;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_tag_reg, out_way_reg, out_set_reg, out_hit_reg};

    // Effective configuration
    always_comb
    begin
        ab        = (address_bits_reg > 6'd32) ? 6'd32 : address_bits_reg;
        addr_mask = (33'd1 << ab) - 33'd1;
        ib        = (index_bits_reg > 4'(sac_pkg::SET_W)) ? 4'(sac_pkg::SET_W) : index_bits_reg;
        set_mask  = (9'd1 << ib) - 9'd1;
        tag_shift = {1'b0, offset_bits_reg} + {2'b0, ib};
        if (ways_in_use_reg == 4'd0)
            last_w = '0;
        else if (ways_in_use_reg > 4'(sac_pkg::MAX_WAYS))
            last_w = sac_pkg::WAY_W'(sac_pkg::MAX_WAYS - 1);
        else
            last_w = sac_pkg::WAY_W'(ways_in_use_reg - 4'd1);
    end

    // Shared age / compare unit for the way under visit
    always_comb
    begin
        age_cur = ages_reg[w_reg];
        match   = valid_reg[w_reg] && (tag_q == tag_reg);
        if (match)
            age_new = '0;
        else if (age_cur == sac_pkg::AGE_MAX)
            age_new = age_cur;
        else
            age_new = age_cur + 1'b1;
    end

    assign miss_wb = !hit_reg;

    always_comb
    begin
        state_next = state_reg;
        row_re     = 1'b0;
        tag_re     = 1'b0;
        row_we     = 1'b0;
        tag_we     = 1'b0;
        tag_raddr  = {set_reg, w_reg + 1'b1};
        tag_waddr  = {set_reg, victim_reg};
        row_wdata.valid = valid_reg;
        row_wdata.age   = ages_reg;
        if (miss_wb)
        begin
            row_wdata.valid[victim_reg] = 1'b1;
            row_wdata.age[victim_reg]   = '0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                state_next = ST_READ;
            end
            ST_READ:
            begin
                row_re     = 1'b1;
                tag_re     = 1'b1;
                tag_raddr  = {set_reg, {sac_pkg::WAY_W{1'b0}}};
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (w_reg == last_w)
                    state_next = ST_WB;
                else
                    tag_re = 1'b1;
            end
            ST_WB:
            begin
                if (out_free)
                begin
                    row_we     = 1'b1;
                    tag_we     = miss_wb;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
            row_mem[set_reg] <= row_wdata;
        if (row_re)
            row_q <= row_mem[set_reg];
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
            tag_mem[tag_waddr] <= tag_reg;
        if (tag_re)
            tag_q <= tag_mem[tag_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            address_bits_reg <= sac_pkg::RST_ADDRESS_BITS;
            offset_bits_reg  <= sac_pkg::RST_OFFSET_BITS;
            index_bits_reg   <= sac_pkg::RST_INDEX_BITS;
            ways_in_use_reg  <= sac_pkg::RST_WAYS_IN_USE;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                sac_pkg::REG_ADDRESS_BITS: address_bits_reg <= cfg_wdata;
                sac_pkg::REG_OFFSET_BITS:  offset_bits_reg  <= cfg_wdata[4:0];
                sac_pkg::REG_INDEX_BITS:   index_bits_reg   <= cfg_wdata[3:0];
                sac_pkg::REG_WAYS_IN_USE:  ways_in_use_reg  <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (row_we)
                row_valid_reg[set_reg] <= 1'b1;
            if (state_reg == ST_WB && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    addr_reg <= s_tdata & addr_mask[31:0];
            end
            ST_PREP:
            begin
                set_reg <= sac_pkg::SET_W'((addr_reg >> offset_bits_reg) & {23'b0, set_mask});
                tag_reg <= addr_reg >> tag_shift;
            end
            ST_LOAD:
            begin
                // untouched sets read as empty with zero ages
                valid_reg <= row_valid_reg[set_reg] ? row_q.valid : '0;
                ages_reg  <= row_valid_reg[set_reg] ? row_q.age : '0;
                w_reg     <= '0;
                hit_reg   <= 1'b0;
                way_reg   <= '0;
                free_reg  <= 1'b0;
                victim_reg <= '0;
                best_reg  <= '0;
            end
            ST_SCAN:
            begin
                ages_reg[w_reg] <= age_new;
                w_reg           <= w_reg + 1'b1;
                if (match && !hit_reg)
                begin
                    hit_reg <= 1'b1;
                    way_reg <= w_reg;
                end
                // victim: lowest empty way, else oldest, lowest on ties
                if (!free_reg)
                begin
                    if (!valid_reg[w_reg])
                    begin
                        free_reg   <= 1'b1;
                        victim_reg <= w_reg;
                    end
                    else if (w_reg == '0 || age_new > best_reg)
                    begin
                        best_reg   <= age_new;
                        victim_reg <= w_reg;
                    end
                end
            end
            ST_WB:
            begin
                if (out_free)
                begin
                    out_hit_reg <= hit_reg;
                    out_set_reg <= set_reg;
                    out_way_reg <= hit_reg ? way_reg : victim_reg;
                    out_tag_reg <= tag_reg;
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_accept_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_PREP))
        else $error("accepted address did not start a lookup");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (w_reg <= last_w))
        else $error("way scan ran past the ways in use");

    a_wb_way_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WB) |-> ((hit_reg ? way_reg : victim_reg) <= last_w))
        else $error("selected way outside the ways in use");

    a_row_marked: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WB && out_free) |=> row_valid_reg[$past(set_reg)])
        else $error("written set not marked valid");

    a_result_follows_wb: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WB && out_free) |=> (m_tvalid && state_reg == ST_IDLE))
        else $error("write-back did not present a result");
`endif

endmodule
